@@ hdl/fdx_pkg.sv @@
// ----------------------------------------------------------------------------
// fdx_pkg
// Shared types and constants for the framed xor-checksum decoder.
// ----------------------------------------------------------------------------
package fdx_pkg;

  // largest payload the buffer is built for
  localparam int MAX_PAYLOAD_DEF = 64;

  // frame start marker
  localparam logic [7:0] START_BYTE = 8'hFE;

  // limit register value after reset
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  // request from the parser to the drain sequencer for one good frame
  typedef struct packed {
    logic        valid;
    logic [15:0] func;
    logic [6:0]  len;
  } drain_req_t;

endpackage

@@ hdl/frame_decoder_xor_checksum.sv @@
// Results: the first result of a good frame passes the read sequencer, the
//   pending read stage and the output register once its checksum request is
//   accepted; results then follow at one per cycle while out_stall is low.
// Throughput: one received byte per cycle while parsing; stalled while draining.
// Reset: synchronous, clears parser and drain control, limit returns to 64;
//   the payload buffer is not cleared.
// ----------------------------------------------------------------------------
// frame_decoder_xor_checksum
// Start/length framed decoder with xor checksum and payload buffer.
// ----------------------------------------------------------------------------
module frame_decoder_xor_checksum #(
  parameter int MAX_PAYLOAD = fdx_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_max_payload_length,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_function_code,
  output logic [6:0]  out_payload_length,
  output logic        out_has_payload,
  output logic [5:0]  out_byte_index,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [6:0]          limit_r;
  logic                busy;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;
  fdx_pkg::drain_req_t req;

  // limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= fdx_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_max_payload_length;
    end
  end

  assign in_stall = busy;

  // header parser and checksum
  fdx_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .busy    (busy),
    .rx_byte (in_rx_byte),
    .limit   (limit_r),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .req     (req)
  );

  // payload buffer
  fdx_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // result sequencer
  fdx_drain #(
    .AW (AW)
  ) u_drain (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .busy              (busy),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_function_code (out_function_code),
    .out_payload_length(out_payload_length),
    .out_has_payload   (out_has_payload),
    .out_byte_index    (out_byte_index),
    .out_payload_byte  (out_payload_byte),
    .out_last          (out_last)
  );

endmodule

@@ hdl/fdx_buf.sv @@
// ----------------------------------------------------------------------------
// fdx_buf
// Payload buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fdx_buf #(
  parameter int DEPTH = fdx_pkg::MAX_PAYLOAD_DEF,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/fdx_parser.sv @@
// ----------------------------------------------------------------------------
// fdx_parser
// Frame header parser: tracks the frame phase, the running xor and writes
// payload bytes into the buffer; issues a drain request on a good checksum.
// ----------------------------------------------------------------------------
module fdx_parser #(
  parameter int MAX_PAYLOAD = fdx_pkg::MAX_PAYLOAD_DEF,
  parameter int AW          = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               busy,
  input  logic [7:0]         rx_byte,
  input  logic [6:0]         limit,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output fdx_pkg::drain_req_t req
);

  localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_FUNC_HI,
    ST_FUNC_LO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DATA,
    ST_CHECK
  } phase_t;

  phase_t              state_r, state_nxt;
  logic [15:0]         func_r, func_nxt;
  logic [7:0]          len_hi_r, len_hi_nxt;
  logic [6:0]          len_r, len_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [7:0]          xor_r, xor_nxt;
  fdx_pkg::drain_req_t req_r, req_nxt;

  logic        accept;
  logic [15:0] len_full;
  logic [6:0]  eff_limit;
  logic [6:0]  cnt_inc;

  assign accept    = in_valid & ~busy;
  assign len_full  = {len_hi_r, rx_byte};
  assign eff_limit = (limit > MAX_LEN) ? MAX_LEN : limit;
  assign cnt_inc   = cnt_r + 7'd1;

  // payload write into the buffer
  assign wr_en   = accept && (state_r == ST_DATA);
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = rx_byte;

  // next-state logic
  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    xor_nxt    = xor_r;
    req_nxt    = req_r;
    req_nxt.valid = 1'b0;
    if (accept) begin
      unique case (state_r)
        ST_FUNC_HI: begin
          func_nxt  = {rx_byte, 8'd0};
          xor_nxt   = xor_r ^ rx_byte;
          state_nxt = ST_FUNC_LO;
        end
        ST_FUNC_LO: begin
          func_nxt  = {func_r[15:8], rx_byte};
          xor_nxt   = xor_r ^ rx_byte;
          state_nxt = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          len_hi_nxt = rx_byte;
          xor_nxt    = xor_r ^ rx_byte;
          state_nxt  = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          xor_nxt = xor_r ^ rx_byte;
          cnt_nxt = 7'd0;
          len_nxt = len_full[6:0];
          if (len_full == 16'd0) begin
            state_nxt = ST_CHECK;
          end else if (len_full > {9'd0, eff_limit}) begin
            state_nxt = ST_WAIT;
          end else begin
            state_nxt = ST_DATA;
          end
        end
        ST_DATA: begin
          cnt_nxt = cnt_inc;
          xor_nxt = xor_r ^ rx_byte;
          if (cnt_inc >= len_r) begin
            state_nxt = ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (xor_r == rx_byte) begin
            req_nxt.valid = 1'b1;
            req_nxt.func  = func_r;
            req_nxt.len   = len_r;
          end
          state_nxt = ST_WAIT;
        end
        default: begin
          if (rx_byte == fdx_pkg::START_BYTE) begin
            xor_nxt   = fdx_pkg::START_BYTE;
            state_nxt = ST_FUNC_HI;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      endcase
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_WAIT;
      req_r     <= '0;
      func_r    <= '0;
      len_hi_r  <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      xor_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      req_r     <= req_nxt;
      func_r    <= func_nxt;
      len_hi_r  <= len_hi_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
    end
  end

  assign req = req_r;

endmodule

@@ hdl/fdx_drain.sv @@
// ----------------------------------------------------------------------------
// fdx_drain
// Drain sequencer: reads a good frame's payload out of the buffer and presents
// one result per byte (one for an empty frame) through an output register.
// ----------------------------------------------------------------------------
module fdx_drain #(
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fdx_pkg::drain_req_t req,
  output logic                busy,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_function_code,
  output logic [6:0]          out_payload_length,
  output logic                out_has_payload,
  output logic [5:0]          out_byte_index,
  output logic [7:0]          out_payload_byte,
  output logic                out_last
);

  // frame being drained
  logic [6:0]  cnt_r;
  logic [5:0]  idx_r;
  logic [15:0] func_r;
  logic [6:0]  len_r;
  logic        empty_r;

  // read in flight, data sits in the buffer read register
  logic        p_r;
  logic [5:0]  p_idx_r;
  logic        p_last_r;
  logic        p_has_r;
  logic [15:0] p_func_r;
  logic [6:0]  p_len_r;

  // output register
  logic        o_valid_r;
  logic [15:0] o_func_r;
  logic [6:0]  o_len_r;
  logic        o_has_r;
  logic [5:0]  o_idx_r;
  logic [7:0]  o_byte_r;
  logic        o_last_r;

  logic o_free;
  logic load_out;
  logic p_free;
  logic issue;

  assign o_free   = ~o_valid_r | ~out_stall;
  assign load_out = p_r & o_free;
  assign p_free   = ~p_r | load_out;
  assign issue    = (cnt_r != 7'd0) & p_free;

  assign rd_en   = issue & ~empty_r;
  assign rd_addr = idx_r[AW-1:0];
  assign busy    = (cnt_r != 7'd0) | p_r | req.valid;

  // read sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.valid) begin
      cnt_r <= (req.len == 7'd0) ? 7'd1 : req.len;
    end else if (issue) begin
      cnt_r <= cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      idx_r   <= '0;
      func_r  <= req.func;
      len_r   <= req.len;
      empty_r <= (req.len == 7'd0);
    end else if (issue) begin
      idx_r <= idx_r + 6'd1;
    end
  end

  // pending read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= 1'b0;
    end else if (p_free) begin
      p_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx_r  <= idx_r;
      p_last_r <= (cnt_r == 7'd1);
      p_has_r  <= ~empty_r;
      p_func_r <= func_r;
      p_len_r  <= len_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_free) begin
      o_valid_r <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_func_r <= p_func_r;
      o_len_r  <= p_len_r;
      o_has_r  <= p_has_r;
      o_idx_r  <= p_idx_r;
      o_byte_r <= p_has_r ? rd_data : 8'd0;
      o_last_r <= p_last_r;
    end
  end

  assign out_valid          = o_valid_r;
  assign out_function_code  = o_func_r;
  assign out_payload_length = o_len_r;
  assign out_has_payload    = o_has_r;
  assign out_byte_index     = o_idx_r;
  assign out_payload_byte   = o_byte_r;
  assign out_last           = o_last_r;

  // a new frame only arrives when the sequencer is idle
  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (cnt_r == 7'd0) && !p_r)
    else $error("drain request while previous frame still in flight");

  // the final result leaves only after every read has been issued
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && p_last_r) |-> (cnt_r == 7'd0))
    else $error("last result with reads outstanding");

  // a blocked pending read keeps its buffer data
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p_r && !load_out) |=> p_r && $stable(rd_data))
    else $error("pending read data lost");

endmodule
